// File: rtl/ppd_pkg.sv
// Shared types and constants of the path point densifier.
// No dependencies.
`default_nettype none
package ppd_pkg;
   localparam int SPACING_WIDTH = 16;
   localparam logic [SPACING_WIDTH-1:0] SPACING_RESET = 16'd100;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture input word and clear counters
      logic seg_step;  // test one more segment count
      logic div_start; // start division for current point
      logic div_step;  // one quotient bit for x and y
      logic out_load;  // latch current point into output register
      logic wp_sel;    // pick the waypoint itself for the output word
      logic commit;    // move input word into previous point
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic passthru;  // new path or no previous point
      logic seg_done;  // segment search finished
      logic div_done;  // both quotients ready
      logic last_pt;   // no interior point after the current index
   } stat_type;
endpackage
`default_nettype wire

// File: rtl/ppd_datapath.sv
// Datapath of the path point densifier: segment search, serial dividers, output word.
// Depends on ppd_pkg.
`default_nettype none
module ppd_datapath
   import ppd_pkg::*;
#(
   parameter int COORD_WIDTH  = 24,
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [SPACING_WIDTH-1:0] spacing,
   input  wire logic [COORD_WIDTH-1:0]   in_x,
   input  wire logic [COORD_WIDTH-1:0]   in_y,
   input  wire logic                     in_start,
   input  wire cmd_type                  cmd,
   output stat_type                      stat,
   output logic [COORD_WIDTH-1:0]        out_x,
   output logic [COORD_WIDTH-1:0]        out_y,
   output logic                          out_wp,
   output logic                          out_last
);
   localparam int CW  = COORD_WIDTH;
   localparam int NW  = $clog2(MAX_SEGMENTS + 1);
   localparam int DW  = CW + 1;          // difference width
   localparam int PW  = DW + NW;         // product j*|d| width
   localparam int SQW = 2 * DW + 1;      // squared distance width
   localparam int SNW = SPACING_WIDTH + NW;
   localparam int CMPW = (2 * SNW > SQW) ? 2 * SNW : SQW;
   localparam int BW  = $clog2(PW + 1);

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, px_ff, py_ff;
   logic start_ff, have_ff;
   logic [SQW-1:0] d2_ff;
   logic [NW-1:0] n_ff, j_ff;
   logic [SNW-1:0] ns_ff;       // n * spacing, grown by spacing (1 when spacing is zero) each step
   logic [2*SNW-1:0] sq_ff;     // (n*spacing)^2 registered
   logic sq_vld_ff;
   logic [PW-1:0] remx_ff, remy_ff, qx_ff, qy_ff;
   logic [BW-1:0] bit_ff;
   logic ox_neg_ff, oy_neg_ff;
   logic [DW-1:0] adx_ff, ady_ff;
   logic [2*DW-1:0] sqx_ff, sqy_ff;
   logic [1:0] d2_phase_ff;

   logic signed [DW-1:0] dx, dy;
   logic [SPACING_WIDTH-1:0] s_eff;
   assign dx = DW'(x_ff) - DW'(px_ff);
   assign dy = DW'(y_ff) - DW'(py_ff);
   assign s_eff = (spacing == '0) ? SPACING_WIDTH'(1) : spacing;
   assign x_in = in_x;
   assign y_in = in_y;

   // capture word, compute squared distance through registered absolute differences, squares and sum
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= x_in;
         y_ff <= y_in;
         start_ff <= in_start;
      end
      adx_ff <= dx[DW-1] ? DW'(-dx) : DW'(dx);
      ady_ff <= dy[DW-1] ? DW'(-dy) : DW'(dy);
      sqx_ff <= adx_ff * adx_ff;
      sqy_ff <= ady_ff * ady_ff;
      d2_ff  <= SQW'(sqx_ff) + SQW'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         px_ff <= '0;
         py_ff <= '0;
      end else if (cmd.commit) begin
         have_ff <= 1'b1;
         px_ff <= x_ff;
         py_ff <= y_ff;
      end
   end

   // segment search: square of n*s registered, then compared
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= '0;
         ns_ff <= '0;
         sq_vld_ff <= 1'b0;
         d2_phase_ff <= '0;
      end else if (d2_phase_ff != 2'd3) begin
         d2_phase_ff <= d2_phase_ff + 2'd1;
      end else if (cmd.seg_step) begin
         if (!sq_vld_ff) begin
            sq_ff <= ns_ff * ns_ff;
            sq_vld_ff <= 1'b1;
         end else if (!stat.seg_done) begin
            n_ff <= n_ff + NW'(1);
            ns_ff <= ns_ff + SNW'(s_eff);
            sq_vld_ff <= 1'b0;
         end
      end
   end

   // report status to the controller
   always_comb begin
      stat.seg_done = (d2_phase_ff == 2'd3) && sq_vld_ff &&
         ((n_ff == NW'(MAX_SEGMENTS)) || (CMPW'(sq_ff) >= CMPW'(d2_ff)));
      stat.passthru = start_ff || !have_ff;
      stat.last_pt  = (j_ff + NW'(1) >= n_ff);
      stat.div_done = (bit_ff == BW'(PW));
   end

   // restoring divide of j*|d| by n, one bit per step for x and y
   logic [PW:0] trx, try_;
   always_comb begin
      trx  = {remx_ff, qx_ff[PW-1]};
      try_ = {remy_ff, qy_ff[PW-1]};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         j_ff <= '0;
      end else if (cmd.div_start) begin
         j_ff <= j_ff + NW'(1);
         remx_ff <= '0;
         remy_ff <= '0;
         qx_ff <= PW'(j_ff + NW'(1)) * PW'(dx[DW-1] ? DW'(-dx) : DW'(dx));
         qy_ff <= PW'(j_ff + NW'(1)) * PW'(dy[DW-1] ? DW'(-dy) : DW'(dy));
         ox_neg_ff <= dx[DW-1];
         oy_neg_ff <= dy[DW-1];
         bit_ff <= '0;
      end else if (cmd.div_step) begin
         if (trx >= (PW+1)'(n_ff)) begin
            remx_ff <= PW'(trx - (PW+1)'(n_ff));
            qx_ff <= {qx_ff[PW-2:0], 1'b1};
         end else begin
            remx_ff <= PW'(trx);
            qx_ff <= {qx_ff[PW-2:0], 1'b0};
         end
         if (try_ >= (PW+1)'(n_ff)) begin
            remy_ff <= PW'(try_ - (PW+1)'(n_ff));
            qy_ff <= {qy_ff[PW-2:0], 1'b1};
         end else begin
            remy_ff <= PW'(try_);
            qy_ff <= {qy_ff[PW-2:0], 1'b0};
         end
         bit_ff <= bit_ff + BW'(1);
      end
   end

   // output word: interpolated point or waypoint
   logic [CW-1:0] ix, iy;
   assign ix = px_ff + (ox_neg_ff ? CW'(-qx_ff) : CW'(qx_ff));
   assign iy = py_ff + (oy_neg_ff ? CW'(-qy_ff) : CW'(qy_ff));
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.wp_sel) begin
            out_x <= x_ff;
            out_y <= y_ff;
            out_wp <= 1'b1;
            out_last <= 1'b1;
         end else begin
            out_x <= ix;
            out_y <= iy;
            out_wp <= 1'b0;
            out_last <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/ppd_ctrl.sv
// Controller of the path point densifier: sequences search, division and output.
// Depends on ppd_pkg.
`default_nettype none
module ppd_ctrl
   import ppd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_fire,
   input  wire logic rsp_tready,
   input  wire stat_type stat,
   output cmd_type   cmd,
   output logic      req_tready,
   output logic      rsp_tvalid
);
   localparam logic [2:0] S_IDLE = 3'd0, S_DECIDE = 3'd1, S_SEARCH = 3'd2,
      S_DIVST = 3'd3, S_DIV = 3'd4, S_OUT = 3'd5, S_PT = 3'd6;
   logic [2:0] state_ff, state_in;
   logic vld_ff, vld_in;

   always_comb begin
      state_in = state_ff;
      vld_in = vld_ff && !rsp_tready;
      cmd = '0;
      cmd.load = req_fire;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = stat.passthru ? S_OUT : S_SEARCH;
         end
         S_SEARCH: begin
            cmd.seg_step = 1'b1;
            if (stat.seg_done) state_in = stat.last_pt ? S_OUT : S_DIVST;
         end
         S_DIVST: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = !stat.div_done;
            if (stat.div_done) state_in = S_PT;
         end
         S_PT: begin
            // hold the interior point until output register is free
            if (!vld_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               vld_in = 1'b1;
               state_in = stat.last_pt ? S_OUT : S_DIVST;
            end
         end
         S_OUT: begin
            // hold the waypoint until output register is free
            if (!vld_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               cmd.wp_sel = 1'b1;
               cmd.commit = 1'b1;
               vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
   end
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = vld_ff;
endmodule
`default_nettype wire

// File: rtl/path_point_densifier.sv
// Top level of the path point densifier: controller, datapath and config register.
// Depends on ppd_pkg, ppd_ctrl, ppd_datapath.
`default_nettype none
// One waypoint word is taken at a time. A path start passes straight to the output;
// a later waypoint first runs the distance and segment search, then yields its
// interior points from the serial restoring divider that yields one quotient bit
// per cycle. A result word that waits on rsp_tready stalls the next output.
module path_point_densifier
   import ppd_pkg::*;
#(
   parameter int COORD_WIDTH  = 24,
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wen,
   input  wire logic [SPACING_WIDTH-1:0] csr_wdata,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // point_x, point_y, zero fill
   input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  wire logic                     req_tuser,   // path_start
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // out_x, out_y, zero fill
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic                          rsp_tuser,   // is_waypoint
   output logic                          rsp_tlast    // last_of_run
);
   localparam int TW = ((2*COORD_WIDTH+7)/8)*8;
   logic [SPACING_WIDTH-1:0] spacing_ff;
   cmd_type cmd;
   stat_type stat;
   logic [COORD_WIDTH-1:0] ox, oy;

   // hold the spacing register
   always_ff @(posedge clock) begin
      if (reset) spacing_ff <= SPACING_RESET;
      else if (csr_wen) spacing_ff <= csr_wdata;
   end

   ppd_ctrl u_ctrl (
      .clock, .reset, .req_fire(req_tvalid && req_tready), .rsp_tready,
      .stat, .cmd, .req_tready, .rsp_tvalid
   );

   ppd_datapath #(.COORD_WIDTH(COORD_WIDTH), .MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
      .clock, .reset, .spacing(spacing_ff),
      .in_x(req_tdata[COORD_WIDTH-1:0]),
      .in_y(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .in_start(req_tuser), .cmd, .stat,
      .out_x(ox), .out_y(oy), .out_wp(rsp_tuser), .out_last(rsp_tlast)
   );
   assign rsp_tdata = TW'({oy, ox});
endmodule
`default_nettype wire

// File: rtl/ppd_checker.sv
// Port-level checker for the path point densifier, bound to the top level.
// Depends on path_point_densifier.
`default_nettype none
module ppd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic rsp_tuser,
   input wire logic rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("rsp dropped");
   a_wp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast)) else $error("waypoint flag");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("accept while busy");
endmodule
bind path_point_densifier ppd_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tuser, .rsp_tlast
);
`default_nettype wire
